[rtl/core/mh2_pkg.sv]
`timescale 1ns / 1ps

package mh2_pkg;

  // Hash constants.
  localparam logic [31:0] MUR_M = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT = 24;
  localparam int unsigned AVAL_SHIFT_A = 13;
  localparam int unsigned AVAL_SHIFT_B = 15;

  // Width of the message length field and default length width.
  localparam int unsigned LEN_W = 16;
  localparam int unsigned DEF_LENGTH_BITS = 16;

  // Operand codes for the shared multiplier.
  localparam logic [2:0] MUL_WORD    = 3'd0;
  localparam logic [2:0] MUL_KMIX    = 3'd1;
  localparam logic [2:0] MUL_HASH    = 3'd2;
  localparam logic [2:0] MUL_TAIL    = 3'd3;
  localparam logic [2:0] MUL_AV_HASH = 3'd4;
  localparam logic [2:0] MUL_AV_PROD = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       k_load;
    logic       hash_mix;
    logic       emit;
  } mh2_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic word_full;
    logic tail;
    logic out_free;
  } mh2_status_t;

endpackage

[rtl/core/murmur2_hash_engine.sv]
`timescale 1ns / 1ps
// MurmurHash2 (32-bit, seed zero) over a byte message, one byte per item.
// Input channel (byte_valid / byte_ready): each item carries one byte, a
// has_byte flag, first and last markers, and the message length, which seeds
// the hash on the first item. An empty message is a single item with first
// and last set and has_byte clear.
// Output channel (hash_valid / hash_ready): one item per message, holding the
// finished hash, produced after the item marked last.
// A byte that neither completes a word nor ends the message is taken at once.
// The fourth byte of a word holds the input while the three constant
// multiplies of the word mix run one after another on a single shared
// multiplier. After the item marked last the engine is busy with the word
// mix when that item completes a word, then a tail fold when bytes are left
// over, then the final avalanche, and takes no input until it has written
// the hash to the output register.
// Stalls: the result sits in an output register. If the receiver stalls with
// a result still held, the next message's bytes are still taken, and the
// engine waits only when it needs to write its next result.
// Reset (rst, synchronous) clears the running hash, the pending bytes and the
// output valid flag.

module murmur2_hash_engine import mh2_pkg::*; #(
  parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  logic [7:0]       data_byte,
  input  logic             has_byte,
  input  logic             first,
  input  logic             last,
  input  logic [LEN_W-1:0] message_length,
  output logic             hash_valid,
  input  logic             hash_ready,
  output logic [31:0]      hash_value
);

  mh2_cmd_t    cmd;
  mh2_status_t st;

  // Sequencer: decides which multiply runs in each cycle.
  mh2_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .last       (last),
    .st         (st),
    .cmd        (cmd)
  );

  // Hash state, word packing, shared multiplier and the output register.
  mh2_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .first          (first),
    .message_length (message_length),
    .hash_ready     (hash_ready),
    .hash_valid     (hash_valid),
    .hash_value     (hash_value)
  );

`ifndef NO_ASSERTIONS
  // A byte that neither completes a word nor ends the message leaves the engine ready.
  a_short_item: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && byte_ready && !last && !st.word_full) |=> byte_ready)
    else $error("engine stalled after a plain byte");

  // Ending a message always takes the engine busy for finalization.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && byte_ready && last) |=> !byte_ready)
    else $error("engine took an item right after the last one");

  // A result is written only when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("result written over a held result");

  // A completed word always starts the mixing sequence.
  a_word_mix: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && byte_ready && st.word_full) |=> (cmd.mul_en && !byte_ready))
    else $error("full word did not start mixing");
`endif

endmodule

[rtl/core/mh2_datapath.sv]
`timescale 1ns / 1ps

module mh2_datapath import mh2_pkg::*; #(
  parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  mh2_cmd_t         cmd,
  output mh2_status_t      st,
  input  logic [7:0]       data_byte,
  input  logic             has_byte,
  input  logic             first,
  input  logic [LEN_W-1:0] message_length,
  input  logic             hash_ready,
  output logic             hash_valid,
  output logic [31:0]      hash_value
);

  localparam int unsigned SeedBits = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
  localparam logic [LEN_W-1:0] LenMask = LEN_W'((33'd1 << SeedBits) - 33'd1);

  logic [31:0] hash;
  logic [23:0] pend;
  logic [1:0]  phase;
  logic [31:0] k;
  logic [31:0] prod;

  logic [31:0] hash_eff;
  logic [23:0] pend_eff;
  logic [1:0]  phase_eff;
  logic [23:0] pend_pack;
  logic [31:0] mul_a;
  logic [31:0] tail_h;

  // The first item of a message restarts the hash from the length seed.
  assign hash_eff  = first ? {16'd0, message_length & LenMask} : hash;
  assign pend_eff  = first ? 24'd0 : pend;
  assign phase_eff = first ? 2'd0 : phase;

  always_comb begin
    case (phase_eff)
      2'd0:    pend_pack = {16'd0, data_byte};
      2'd1:    pend_pack = {8'd0, data_byte, pend_eff[7:0]};
      default: pend_pack = {data_byte, pend_eff[15:0]};
    endcase
  end

  assign tail_h = hash ^ {8'd0, pend};

  always_comb begin
    case (cmd.mul_sel)
      MUL_WORD:    mul_a = k;
      MUL_KMIX:    mul_a = prod ^ (prod >> MIX_SHIFT);
      MUL_HASH:    mul_a = hash;
      MUL_TAIL:    mul_a = tail_h;
      MUL_AV_HASH: mul_a = hash ^ (hash >> AVAL_SHIFT_A);
      MUL_AV_PROD: mul_a = prod ^ (prod >> AVAL_SHIFT_A);
      default:     mul_a = 32'd0;
    endcase
  end

  assign st.word_full = has_byte && (phase_eff == 2'd3);
  assign st.tail      = (phase != 2'd0);
  assign st.out_free  = !hash_valid || hash_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash  <= 32'd0;
      pend  <= 24'd0;
      phase <= 2'd0;
    end else if (cmd.emit) begin
      hash  <= 32'd0;
      pend  <= 24'd0;
      phase <= 2'd0;
    end else if (cmd.load) begin
      hash <= hash_eff;
      if (has_byte && (phase_eff == 2'd3)) begin
        pend  <= 24'd0;
        phase <= 2'd0;
      end else if (has_byte) begin
        pend  <= pend_pack;
        phase <= phase_eff + 2'd1;
      end else begin
        pend  <= pend_eff;
        phase <= phase_eff;
      end
    end else if (cmd.hash_mix) begin
      hash <= prod ^ k;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k <= {data_byte, pend_eff};
    end else if (cmd.k_load) begin
      k <= prod;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * MUR_M;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (cmd.emit) begin
      hash_valid <= 1'b1;
    end else if (hash_ready) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hash_value <= prod ^ (prod >> AVAL_SHIFT_B);
    end
  end

endmodule

[rtl/core/mh2_ctrl.sv]
`timescale 1ns / 1ps

module mh2_ctrl import mh2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic        last,
  input  mh2_status_t st,
  output mh2_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIX0 = 3'd1;
  localparam logic [2:0] S_MIX1 = 3'd2;
  localparam logic [2:0] S_MIX2 = 3'd3;
  localparam logic [2:0] S_MIX3 = 3'd4;
  localparam logic [2:0] S_TAIL = 3'd5;
  localparam logic [2:0] S_AVAL = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       fin;
  logic       fin_next;

  always_comb begin
    state_next = state;
    fin_next   = fin;
    cmd        = '0;
    byte_ready = 1'b0;
    case (state)
      S_IDLE: begin
        byte_ready = 1'b1;
        if (byte_valid) begin
          cmd.load = 1'b1;
          fin_next = last;
          if (st.word_full) begin
            state_next = S_MIX0;
          end else if (last) begin
            state_next = S_TAIL;
          end
        end
      end
      S_MIX0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WORD;
        state_next  = S_MIX1;
      end
      S_MIX1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KMIX;
        state_next  = S_MIX2;
      end
      S_MIX2: begin
        cmd.k_load  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HASH;
        state_next  = S_MIX3;
      end
      S_MIX3: begin
        cmd.hash_mix = 1'b1;
        state_next   = fin ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        cmd.mul_en = 1'b1;
        if (st.tail) begin
          cmd.mul_sel = MUL_TAIL;
          state_next  = S_AVAL;
        end else begin
          cmd.mul_sel = MUL_AV_HASH;
          state_next  = S_OUT;
        end
      end
      S_AVAL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AV_PROD;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          fin_next   = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end

endmodule
